// ----- design/tcce_pkg.sv -----
package tcce_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 8;
	localparam int CELL_W   = 16;
	localparam int ROW_FW   = 5;
	localparam int COL_FW   = 7;

	localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
	localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic              func;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_FW-1:0] read_row;
		logic [COL_FW-1:0] read_col;
	} req_item_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic [ROW_FW-1:0] cursor_row;
		logic [COL_FW-1:0] cursor_col;
		logic              scrolled;
	} rsp_item_t;

endpackage

// ----- design/text_console_cursor_engine_core.sv -----
// Channel | Direction | Handshake              | Item
// req     | in        | req_valid / req_stall  | req_item_t  (func, char_code, read_row, read_col)
// rsp     | out       | rsp_valid / rsp_stall  | rsp_item_t  (cell_value, cursor, scrolled)
// cfg     | in        | cfg_we                 | cfg_data    (text_color)
//
// Put: one RAM write, then the result register loads.
// Read: the RAM read is registered, then the cell result, then the result register.
// A put or newline that scrolls adds one RAM write per cell of the recycled
// row; the top row is a rotating pointer, so nothing is copied.
// After reset every RAM cell is swept to 0x0720 before the first item is
// taken. A stalled result holds only the final state, ST_DONE.
module text_console_cursor_engine_core
	import tcce_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_item_t          req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_item_t          rsp,
	input  logic               cfg_we,
	input  logic [COLOR_W-1:0] cfg_data
);

	localparam int NCELLS = ROWS * COLUMNS;
	localparam int AW     = $clog2(NCELLS);
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLUMNS);
	localparam int SW     = ((RW > ROW_FW) ? RW : ROW_FW) + 1;

	typedef enum logic [2:0] {
		ST_CLR_ALL,
		ST_IDLE,
		ST_READ,
		ST_CLR_ROW,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [RW-1:0]      cur_row_q;
	logic [CW-1:0]      cur_col_q;
	logic [RW-1:0]      top_q;
	logic [RW-1:0]      clr_row_q;
	logic [CW-1:0]      clr_col_q;
	logic [COLOR_W-1:0] color_q;
	logic               rd_ok_q;
	logic [CELL_W-1:0]  res_cell_q;
	logic               res_scr_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;
	logic [CELL_W-1:0]  rd_data_q;

	logic [CELL_W-1:0]  mem [NCELLS];

	logic               mem_we;
	logic [RW-1:0]      mem_row;
	logic [CW-1:0]      mem_col;
	logic [CELL_W-1:0]  mem_wdata;
	logic [AW-1:0]      mem_addr;
	logic [RW-1:0]      cur_prow;
	logic [RW-1:0]      rd_prow;
	logic               is_nl;

	function automatic logic [RW-1:0] phys_row(input logic [SW-1:0] lr,
		input logic [RW-1:0] top);
		logic [SW-1:0] s;
		s = lr + SW'(top);
		if (s >= SW'(ROWS))
			s = s - SW'(ROWS);
		return RW'(s);
	endfunction

	assign cur_prow = phys_row(SW'(cur_row_q), top_q);
	assign rd_prow  = phys_row(SW'(req.read_row), top_q);
	assign is_nl    = (req.char_code == NEWLINE_CHAR);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_row   = cur_prow;
		mem_col   = cur_col_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLR_ALL: begin
				mem_we    = 1'b1;
				mem_row   = clr_row_q;
				mem_col   = clr_col_q;
				mem_wdata = {RESET_COLOR, BLANK_CHAR};
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req.func == FUNC_READ) begin
						mem_row = rd_prow;
						mem_col = CW'(req.read_col);
					end else if (!is_nl) begin
						mem_we    = 1'b1;
						mem_wdata = {color_q, req.char_code};
					end
				end
			end
			ST_CLR_ROW: begin
				mem_we  = 1'b1;
				mem_row = clr_row_q;
				mem_col = clr_col_q;
			end
			default: begin
			end
		endcase
	end

	// shared address unit: row * COLUMNS + col
	assign mem_addr = AW'(AW'(mem_row) * AW'(COLUMNS) + AW'(mem_col));

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rd_data_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR_ALL;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			top_q       <= '0;
			clr_row_q   <= '0;
			clr_col_q   <= '0;
			color_q     <= RESET_COLOR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				color_q <= cfg_data;
			if (rsp_valid_q && !rsp_stall && state_q != ST_DONE)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_CLR_ALL: begin
					if (clr_col_q == CW'(COLUMNS - 1)) begin
						clr_col_q <= '0;
						if (clr_row_q == RW'(ROWS - 1)) begin
							clr_row_q <= '0;
							state_q   <= ST_IDLE;
						end else begin
							clr_row_q <= clr_row_q + 1'b1;
						end
					end else begin
						clr_col_q <= clr_col_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						res_cell_q <= '0;
						res_scr_q  <= 1'b0;
						rd_ok_q    <= (int'(req.read_row) < ROWS) &&
							(int'(req.read_col) < COLUMNS);
						if (req.func == FUNC_READ) begin
							state_q <= ST_READ;
						end else if (is_nl || cur_col_q == CW'(COLUMNS - 1)) begin
							cur_col_q <= '0;
							if (cur_row_q == RW'(ROWS - 1)) begin
								// recycle the top row as the new bottom row
								clr_row_q <= top_q;
								clr_col_q <= '0;
								top_q     <= (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
								res_scr_q <= 1'b1;
								state_q   <= ST_CLR_ROW;
							end else begin
								cur_row_q <= cur_row_q + 1'b1;
								state_q   <= ST_DONE;
							end
						end else begin
							cur_col_q <= cur_col_q + 1'b1;
							state_q   <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					res_cell_q <= rd_ok_q ? rd_data_q : '0;
					state_q    <= ST_DONE;
				end
				ST_CLR_ROW: begin
					if (clr_col_q == CW'(COLUMNS - 1)) begin
						clr_col_q <= '0;
						state_q   <= ST_DONE;
					end else begin
						clr_col_q <= clr_col_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.cell_value    <= res_cell_q;
						rsp_q.cursor_row    <= ROW_FW'(cur_row_q);
						rsp_q.cursor_col    <= COL_FW'(cur_col_q);
						rsp_q.scrolled      <= res_scr_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR_ALL) |-> req_stall)
		else $error("item accepted during reset sweep");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("second item accepted while busy");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cur_row_q) < ROWS) && (int'(cur_col_q) < COLUMNS) && (int'(top_q) < ROWS))
		else $error("cursor or top row out of range");

	a_scroll_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.scrolled) |-> (rsp.cursor_col == '0))
		else $error("scroll result with nonzero column");

	a_scroll_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR_ROW) |-> (cur_row_q == RW'(ROWS - 1)))
		else $error("row clear while cursor not on last row");

endmodule

// ----- test/text_console_cursor_engine_core_tb.sv -----
class console_shadow;
	localparam int NCOLS = tcce_pkg::COLUMNS_DEF;
	localparam int NROWS = tcce_pkg::ROWS_DEF;

	bit [15:0] glyphs [NROWS*NCOLS];
	int unsigned row_at;
	int unsigned col_at;
	bit [7:0] attr;
	tcce_pkg::rsp_item_t awaited[$];
	int errors;
	int checked;

	function new();
		foreach (glyphs[i])
			glyphs[i] = {tcce_pkg::RESET_COLOR, tcce_pkg::BLANK_CHAR};
		row_at = 0;
		col_at = 0;
		attr = tcce_pkg::RESET_COLOR;
		errors = 0;
		checked = 0;
	endfunction

	function void scroll_up();
		for (int i = 0; i + NCOLS < NROWS*NCOLS; i++)
			glyphs[i] = glyphs[i + NCOLS];
		for (int i = (NROWS - 1)*NCOLS; i < NROWS*NCOLS; i++)
			glyphs[i] = '0;
	endfunction

	function bit line_feed();
		col_at = 0;
		row_at++;
		if (row_at >= NROWS) begin
			scroll_up();
			row_at = NROWS - 1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function void note_request(tcce_pkg::req_item_t it);
		tcce_pkg::rsp_item_t r;
		r = '0;
		if (it.func == tcce_pkg::FUNC_READ) begin
			if (it.read_row < NROWS && it.read_col < NCOLS)
				r.cell_value = glyphs[it.read_row*NCOLS + it.read_col];
		end else if (it.char_code == tcce_pkg::NEWLINE_CHAR) begin
			r.scrolled = line_feed();
		end else begin
			glyphs[row_at*NCOLS + col_at] = {attr, it.char_code};
			col_at++;
			if (col_at >= NCOLS)
				r.scrolled = line_feed();
		end
		r.cursor_row = row_at[4:0];
		r.cursor_col = col_at[6:0];
		awaited.push_back(r);
	endfunction

	function void check_result(tcce_pkg::rsp_item_t got);
		tcce_pkg::rsp_item_t want;
		checked++;
		if (awaited.size() == 0) begin
			errors++;
			$error("result with nothing awaited: %h", got);
			return;
		end
		want = awaited.pop_front();
		if (got.cell_value !== want.cell_value) begin
			errors++;
			$error("cell_value: expected %h, got %h", want.cell_value, got.cell_value);
		end
		if (got.cursor_row !== want.cursor_row) begin
			errors++;
			$error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
		end
		if (got.cursor_col !== want.cursor_col) begin
			errors++;
			$error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
		end
		if (got.scrolled !== want.scrolled) begin
			errors++;
			$error("scrolled: expected %b, got %b", want.scrolled, got.scrolled);
		end
	endfunction

	function int pending();
		return awaited.size();
	endfunction
endclass

module text_console_cursor_engine_core_tb
	import tcce_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int HOLD_OFF_CYCLES = 300;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	req_item_t          req;
	logic               rsp_valid;
	logic               rsp_stall;
	rsp_item_t          rsp;
	logic               cfg_we;
	logic [COLOR_W-1:0] cfg_data;

	bit no_gaps = 1'b0;
	console_shadow shadow = new();

	text_console_cursor_engine_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_item(input req_item_t it);
		while (!no_gaps && $urandom_range(99) < 36) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (req_stall !== 1'b0);
		shadow.note_request(it);
	endtask

	task automatic put_char(input logic [7:0] ch);
		req_item_t it;
		it.func = FUNC_PUT;
		it.char_code = ch;
		it.read_row = 5'($urandom_range(31));
		it.read_col = 7'($urandom_range(127));
		send_item(it);
	endtask

	task automatic read_cell(input int unsigned r, input int unsigned c);
		req_item_t it;
		it.func = FUNC_READ;
		it.char_code = 8'($urandom_range(255));
		it.read_row = r[4:0];
		it.read_col = c[6:0];
		send_item(it);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_color(input logic [7:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.attr = v;
	endtask

	task automatic run_phase(input int n, input int newline_pct, input int read_pct);
		int roll;
		int pick;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(99);
			if (roll < read_pct) begin
				pick = $urandom_range(99);
				if (pick < 40)
					read_cell(shadow.row_at, $urandom_range(COLUMNS_DEF - 1));
				else if (pick < 85)
					read_cell($urandom_range(ROWS_DEF - 1), $urandom_range(COLUMNS_DEF - 1));
				else
					read_cell($urandom_range(31), $urandom_range(127));
			end else if (roll < read_pct + newline_pct) begin
				put_char(NEWLINE_CHAR);
			end else begin
				put_char(8'($urandom_range(255)));
			end
		end
	endtask

	// response side: random stall plus one long hold-off to back up the input
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
				shadow.check_result(rsp);
			if (!hold_done && shadow.checked >= 150) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !no_gaps && ($urandom_range(99) < 36);
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid === 1'b1 && req_stall === 1'b0) ||
			    (rsp_valid === 1'b1 && rsp_stall === 1'b0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("text_console_cursor_engine_core_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// corners, out-of-range reads, extreme chars, newline
		read_cell(0, 0);
		read_cell(ROWS_DEF - 1, COLUMNS_DEF - 1);
		read_cell(ROWS_DEF, 0);
		read_cell(31, 127);
		read_cell(0, COLUMNS_DEF);
		read_cell(ROWS_DEF - 1, 127);
		put_char(8'h00);
		put_char(8'hFF);
		put_char(8'h41);
		put_char(NEWLINE_CHAR);
		put_char(8'h0B);
		read_cell(0, 0);
		read_cell(0, 1);
		read_cell(0, 2);
		read_cell(1, 0);
		write_color(8'hFF);
		put_char(8'h7E);
		read_cell(1, 1);
		write_color(8'h00);
		put_char(8'h55);
		read_cell(1, 2);

		write_color(8'($urandom_range(255)));
		run_phase(200, 12, 38);
		write_color(8'h1E);
		no_gaps = 1'b1;
		run_phase(250, 0, 10);
		no_gaps = 1'b0;
		write_color(8'($urandom_range(255)));
		run_phase(200, 15, 40);
		write_color(8'hFF);
		run_phase(200, 8, 35);
		write_color(RESET_COLOR);
		run_phase(180, 20, 40);

		drain();
		repeat (COLUMNS_DEF + 20) @(posedge clk);
		if (shadow.errors == 0)
			$display("text_console_cursor_engine_core_tb: PASS");
		else
			$display("text_console_cursor_engine_core_tb: FAIL");
		$finish;
	end
endmodule
